/* hdl/scsa_pkg.sv */
`default_nettype none
package scsa_pkg;
   localparam int PageBytesDef   = 4096;
   localparam int ArenaPagesDef  = 64;
   localparam int NumClassesDef  = 8;
   localparam int LargestDef     = 2048;
   localparam int GrainShift     = 4;
   localparam int LinkW          = 15;
   localparam int AddrW          = 18;
   localparam int SizeW          = 16;
   localparam int PfW            = 7;
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Class index for a byte size: ceil(log2(size)) - 4, zero for sizes up to 16.
   function automatic logic [3:0] class_of(input logic [SizeW-1:0] size);
      logic [SizeW-1:0] v;
      logic [4:0] n;
      v = size - 16'd1;
      n = 5'd0;
      for (int i = 0; i < SizeW; i++) begin
         if (v[i]) begin
            n = 5'(i + 1);
         end
      end
      if (size <= 16'd16) begin
         class_of = 4'd0;
      end else begin
         class_of = 4'(n - 5'd4);
      end
   endfunction
endpackage
`default_nettype wire

/* hdl/scsa_link_mem.sv */
`default_nettype none
module scsa_link_mem #(
   parameter int Depth = 16384,
   parameter int AW    = 14
) (
   input  wire                    clock,
   input  wire                    wr_en,
   input  wire [AW-1:0]           wr_addr,
   input  wire [scsa_pkg::LinkW-1:0] wr_data,
   input  wire [AW-1:0]           rd_addr,
   output logic [scsa_pkg::LinkW-1:0] rd_data
);
   import scsa_pkg::*;
   logic [LinkW-1:0] mem [Depth];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* hdl/size_class_slab_allocator.sv */
`default_nettype none
// Flow: each accepted word passes S_DEC and then S_RSP for a free or a refused request; a page
// allocation adds S_PGRD, and a class allocation from a nonempty list adds S_POP and S_POPWT.
// A class refill adds S_PGRD to take a page, then S_CARVE pushes one object per cycle, PAGE_BYTES /
// object size objects (up to 256 for 16-byte objects); the single link memory port sets this.
// One request is in flight at a time and the next word is accepted once the state returns to
// S_IDLE after the result is registered; a waiting result does not
// block the next request, only its result.
// Reset is synchronous: class and page lists become empty, watermark and spare count zero.
module size_class_slab_allocator #(
   parameter int PAGE_BYTES          = scsa_pkg::PageBytesDef,
   parameter int ARENA_PAGES         = scsa_pkg::ArenaPagesDef,
   parameter int NUM_CLASSES         = scsa_pkg::NumClassesDef,
   parameter int LARGEST_CLASS_BYTES = scsa_pkg::LargestDef
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // operation[0], size[16:1], has_object[17], address[35:18], zero[39:36]
   input  wire [39:0]  req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // ok[0], address_res[18:1], pages_free[25:19], zero[31:26]
   output logic [31:0] rsp_tdata
);
   import scsa_pkg::*;
   localparam int GranPerPage = PAGE_BYTES / 16;
   localparam int Depth       = (PAGE_BYTES / 16) * ARENA_PAGES;
   localparam int AW          = $clog2(Depth);
   localparam int GPW         = $clog2(GranPerPage);
   localparam int PW          = (ARENA_PAGES > 1) ? $clog2(ARENA_PAGES) : 1;
   localparam int CW          = 3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_PAGE  = 2'd1;
   localparam logic [1:0] KIND_CLASS = 2'd2;

   typedef enum logic [2:0] {S_IDLE, S_DEC, S_PGRD, S_CARVE, S_POP, S_POPWT, S_RSP}
      state_type;

   state_type state_ff;
   logic op_ff, has_ff;
   logic [SizeW-1:0] size_ff;
   logic [AddrW-1:0] addr_ff;
   logic [LinkW-1:0] chead_ff [8];
   logic [LinkW-1:0] phead_ff;              // page index + 1, zero empty
   logic [PW:0] wm_ff;
   logic [16:0] spare_ff;
   logic [3:0] cls_ff;
   logic [1:0] kind_ff;                      // none, page or class allocation
   logic [LinkW-1:0] base_ff;
   logic [8:0] cnt_ff;
   logic [LinkW-1:0] stride_ff;
   logic ok_ff;
   logic [AddrW-1:0] res_ff;
   logic rv_ff;
   logic [31:0] rd_ff;

   logic we;
   logic [AW-1:0] wa, ra;
   logic [LinkW-1:0] wd, rdat;

   // Class of the request being decoded.
   logic [3:0] cls_dec;
   assign cls_dec = class_of(size_ff);

   scsa_link_mem #(.Depth(Depth), .AW(AW)) u_mem (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rdat));

   logic [AW-1:0] gran_of_phead;
   assign gran_of_phead = AW'(32'(phead_ff - 1'b1) * GranPerPage);

   logic [16:0] pf_full;
   logic [PfW-1:0] pf;
   assign pf_full = 17'(ARENA_PAGES) - 17'(wm_ff) + spare_ff;
   assign pf = (pf_full > 17'd127) ? 7'd127 : pf_full[6:0];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   // Memory port control, one access of each kind a cycle.
   always_comb begin
      we = 1'b0; wa = '0; wd = '0;
      ra = gran_of_phead;
      case (state_ff)
         S_DEC: begin
            if (op_ff == OP_FREE && has_ff) begin
               if (size_ff > 16'(LARGEST_CLASS_BYTES)) begin
                  we = 1'b1;
                  wa = AW'(32'(addr_ff / PAGE_BYTES % ARENA_PAGES) * GranPerPage);
                  wd = (phead_ff == '0) ? '0 : LinkW'(gran_of_phead) + 1'b1;
               end else if (32'(cls_dec) < NUM_CLASSES) begin
                  we = 1'b1;
                  wa = AW'(addr_ff >> GrainShift);
                  wd = chead_ff[cls_dec[CW-1:0]];
               end
            end
         end
         S_CARVE: begin
            we = 1'b1;
            wa = AW'(base_ff);
            wd = chead_ff[cls_ff[CW-1:0]];
         end
         S_POP: ra = AW'(chead_ff[cls_ff[CW-1:0]] - 1'b1);
         default: ;
      endcase
   end

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff <= 1'b0;
         for (int i = 0; i < 8; i++) chead_ff[i] <= '0;
         phead_ff <= '0; wm_ff <= '0; spare_ff <= '0;
      end else begin
         if (rv_ff && rsp_tready && state_ff != S_RSP) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff <= req_tdata[0];
                  size_ff <= req_tdata[16:1];
                  has_ff <= req_tdata[17];
                  addr_ff <= req_tdata[35:18];
                  state_ff <= S_DEC;
               end
            end
            S_DEC: begin
               // Memory read of the page list link is now issued.
               ok_ff <= 1'b1; res_ff <= '0; kind_ff <= KIND_NONE;
               cls_ff <= cls_dec;
               stride_ff <= LinkW'(16'd1 << cls_dec);
               state_ff <= S_RSP;
               if (op_ff == OP_FREE) begin
                  if (has_ff) begin
                     if (size_ff > 16'(LARGEST_CLASS_BYTES)) begin
                        phead_ff <= LinkW'(addr_ff / PAGE_BYTES % ARENA_PAGES) + 1'b1;
                        if (spare_ff < 17'hFFFF) spare_ff <= spare_ff + 1'b1;
                     end else if (32'(cls_dec) < NUM_CLASSES) begin
                        chead_ff[cls_dec[CW-1:0]] <=
                           LinkW'(addr_ff >> GrainShift) + 1'b1;
                     end
                  end
               end else begin
                  ok_ff <= 1'b0;
                  if (size_ff == '0) begin
                  end else if (size_ff > 16'(LARGEST_CLASS_BYTES)) begin
                     if (17'(size_ff) <= 17'(PAGE_BYTES)) begin
                        kind_ff <= KIND_PAGE; state_ff <= S_PGRD;
                     end
                  end else if (32'(cls_dec) < NUM_CLASSES) begin
                     if (chead_ff[cls_dec[CW-1:0]] != '0) begin
                        state_ff <= S_POP;
                     end else begin
                        kind_ff <= KIND_CLASS; state_ff <= S_PGRD;
                     end
                  end
               end
            end
            S_PGRD: begin
               // Take a page: list head first, then watermark.
               state_ff <= S_RSP;
               if (phead_ff != '0) begin
                  phead_ff <= (rdat == '0) ? '0 :
                     LinkW'(32'(rdat - 1'b1) / GranPerPage % ARENA_PAGES) + 1'b1;
                  if (spare_ff != '0) spare_ff <= spare_ff - 1'b1;
                  base_ff <= LinkW'(gran_of_phead);
                  res_ff <= AddrW'(32'(phead_ff - 1'b1) * PAGE_BYTES);
                  ok_ff <= (kind_ff == KIND_PAGE);
                  if (kind_ff == KIND_CLASS) state_ff <= S_CARVE;
               end else if (32'(wm_ff) < ARENA_PAGES) begin
                  wm_ff <= wm_ff + 1'b1;
                  base_ff <= LinkW'(32'(wm_ff) * GranPerPage);
                  res_ff <= AddrW'(32'(wm_ff) * PAGE_BYTES);
                  ok_ff <= (kind_ff == KIND_PAGE);
                  if (kind_ff == KIND_CLASS) state_ff <= S_CARVE;
               end
               cnt_ff <= 9'(GranPerPage >> cls_ff);
            end
            S_CARVE: begin
               // Push one object per cycle, low address first.
               chead_ff[cls_ff[CW-1:0]] <= base_ff + 1'b1;
               base_ff <= base_ff + stride_ff;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == 9'd1) state_ff <= S_POP;
            end
            S_POP: state_ff <= S_POPWT;
            S_POPWT: begin
               chead_ff[cls_ff[CW-1:0]] <= rdat;
               ok_ff <= 1'b1;
               res_ff <= AddrW'({chead_ff[cls_ff[CW-1:0]] - 1'b1, 4'b0});
               state_ff <= S_RSP;
            end
            S_RSP: begin
               if (!rv_ff || rsp_tready) begin
                  rv_ff <= 1'b1;
                  rd_ff <= {6'd0, pf, res_ff, ok_ff};
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp_tready |=> rv_ff) else $error("result dropped");
   a_wm: assert property (@(posedge clock) disable iff (reset)
      32'(wm_ff) <= ARENA_PAGES) else $error("watermark overrun");
endmodule
`default_nettype wire
